/* rtl/core/qrm_pkg.sv */
// ----------------------------------------------------------------------------
// qrm_pkg
// Shared widths, payload types and helpers of the quaternion to matrix block.
// ----------------------------------------------------------------------------
package qrm_pkg;

   localparam int CW    = 16;          // component and element width
   localparam int FW    = CW - 1;      // fraction bits
   localparam int PW    = 2 * CW;      // product width
   localparam int NW    = 2 * CW + 2;  // norm / remainder width
   localparam int SW    = NW + 1;      // signed numerator width
   localparam int QW    = FW + 2;      // raw quotient width
   localparam int NSTEP = FW + 2;      // divider steps
   localparam int NLANE = 9;

   typedef struct packed {
      logic signed [CW-1:0] qw;
      logic signed [CW-1:0] qx;
      logic signed [CW-1:0] qy;
      logic signed [CW-1:0] qz;
   } req_type;

   typedef struct packed {
      logic signed [CW-1:0] r00;
      logic signed [CW-1:0] r01;
      logic signed [CW-1:0] r02;
      logic signed [CW-1:0] r10;
      logic signed [CW-1:0] r11;
      logic signed [CW-1:0] r12;
      logic signed [CW-1:0] r20;
      logic signed [CW-1:0] r21;
      logic signed [CW-1:0] r22;
      logic                 zero_quat;
   } rsp_type;

   typedef struct packed {
      logic signed [PW-1:0] ww;
      logic signed [PW-1:0] xx;
      logic signed [PW-1:0] yy;
      logic signed [PW-1:0] zz;
      logic signed [PW-1:0] xy;
      logic signed [PW-1:0] xz;
      logic signed [PW-1:0] yz;
      logic signed [PW-1:0] wx;
      logic signed [PW-1:0] wy;
      logic signed [PW-1:0] wz;
   } prod_type;

   typedef struct packed {
      logic [NW-1:0]             n;
      logic [NLANE-1:0][NW-1:0]  rem;
      logic [NLANE-1:0][QW-1:0]  q;
      logic [NLANE-1:0]          neg;
      logic                      zero;
   } div_type;

   localparam logic signed [CW-1:0] ONE_SAT = CW'((1 << FW) - 1);

   function automatic logic signed [PW-1:0] smul(input logic signed [CW-1:0] a,
                                                 input logic signed [CW-1:0] b);
      return PW'(a) * PW'(b);
   endfunction

endpackage

/* rtl/core/qrm_mult.sv */
// ----------------------------------------------------------------------------
// qrm_mult
// Product stage: the ten component products, registered.
// ----------------------------------------------------------------------------
module qrm_mult (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  qrm_pkg::req_type   in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output qrm_pkg::prod_type  out_data
);

   logic              valid_ff;
   qrm_pkg::prod_type data_ff, data_in;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      data_in.ww = qrm_pkg::smul(in_data.qw, in_data.qw);
      data_in.xx = qrm_pkg::smul(in_data.qx, in_data.qx);
      data_in.yy = qrm_pkg::smul(in_data.qy, in_data.qy);
      data_in.zz = qrm_pkg::smul(in_data.qz, in_data.qz);
      data_in.xy = qrm_pkg::smul(in_data.qx, in_data.qy);
      data_in.xz = qrm_pkg::smul(in_data.qx, in_data.qz);
      data_in.yz = qrm_pkg::smul(in_data.qy, in_data.qz);
      data_in.wx = qrm_pkg::smul(in_data.qw, in_data.qx);
      data_in.wy = qrm_pkg::smul(in_data.qw, in_data.qy);
      data_in.wz = qrm_pkg::smul(in_data.qw, in_data.qz);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

/* rtl/core/qrm_numer.sv */
// ----------------------------------------------------------------------------
// qrm_numer
// Numerator stage: squared norm, nine signed numerators split into sign and
// magnitude for the dividers.
// ----------------------------------------------------------------------------
module qrm_numer (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  qrm_pkg::prod_type  in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output qrm_pkg::div_type   out_data
);

   logic             valid_ff;
   qrm_pkg::div_type data_ff, data_in;

   logic signed [qrm_pkg::SW-1:0] ww, xx, yy, zz, xy, xz, yz, wx, wy, wz, n_s;
   logic signed [qrm_pkg::SW-1:0] num [qrm_pkg::NLANE];
   logic signed [qrm_pkg::SW-1:0] mag [qrm_pkg::NLANE];

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      ww  = qrm_pkg::SW'(in_data.ww);
      xx  = qrm_pkg::SW'(in_data.xx);
      yy  = qrm_pkg::SW'(in_data.yy);
      zz  = qrm_pkg::SW'(in_data.zz);
      xy  = qrm_pkg::SW'(in_data.xy);
      xz  = qrm_pkg::SW'(in_data.xz);
      yz  = qrm_pkg::SW'(in_data.yz);
      wx  = qrm_pkg::SW'(in_data.wx);
      wy  = qrm_pkg::SW'(in_data.wy);
      wz  = qrm_pkg::SW'(in_data.wz);
      n_s = (ww + xx) + (yy + zz);

      num[0] = n_s - ((yy + zz) <<< 1);
      num[1] = (xy + wz) <<< 1;
      num[2] = (xz - wy) <<< 1;
      num[3] = (xy - wz) <<< 1;
      num[4] = n_s - ((xx + zz) <<< 1);
      num[5] = (yz + wx) <<< 1;
      num[6] = (xz + wy) <<< 1;
      num[7] = (yz - wx) <<< 1;
      num[8] = n_s - ((xx + yy) <<< 1);

      data_in.n    = n_s[qrm_pkg::NW-1:0];
      data_in.zero = (n_s == '0);
      for (int k = 0; k < qrm_pkg::NLANE; k++) begin
         data_in.neg[k] = num[k][qrm_pkg::SW-1];
         mag[k]         = num[k][qrm_pkg::SW-1] ? -num[k] : num[k];
         data_in.rem[k] = mag[k][qrm_pkg::NW-1:0];
         data_in.q[k]   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

/* rtl/core/qrm_div_step.sv */
// ----------------------------------------------------------------------------
// qrm_div_step
// One restoring division step across all nine lanes, registered.
// ----------------------------------------------------------------------------
module qrm_div_step #(
   parameter bit FIRST = 1'b0    // first step takes the integer bit, no shift
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  qrm_pkg::div_type  in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output qrm_pkg::div_type  out_data
);

   logic             valid_ff;
   qrm_pkg::div_type data_ff, data_in;
   logic [qrm_pkg::NW-1:0] trial [qrm_pkg::NLANE];
   logic                   ge    [qrm_pkg::NLANE];

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      data_in = in_data;
      for (int k = 0; k < qrm_pkg::NLANE; k++) begin
         trial[k] = FIRST ? in_data.rem[k] : {in_data.rem[k][qrm_pkg::NW-2:0], 1'b0};
         ge[k]    = (trial[k] >= in_data.n);
         data_in.rem[k] = ge[k] ? (trial[k] - in_data.n) : trial[k];
         data_in.q[k]   = {in_data.q[k][qrm_pkg::QW-2:0], ge[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

/* rtl/core/qrm_round.sv */
// ----------------------------------------------------------------------------
// qrm_round
// Output stage: round half away from zero, apply sign, saturate, and
// substitute the identity for a zero quaternion.
// ----------------------------------------------------------------------------
module qrm_round (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  qrm_pkg::div_type  in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output qrm_pkg::rsp_type  out_data
);

   localparam logic [qrm_pkg::QW-1:0] POS_MAX = qrm_pkg::QW'((1 << qrm_pkg::FW) - 1);
   localparam logic [qrm_pkg::QW-1:0] NEG_MAX = qrm_pkg::QW'(1 << qrm_pkg::FW);
   localparam logic signed [qrm_pkg::CW-1:0] NEG_SAT = qrm_pkg::CW'(1 << qrm_pkg::FW);

   logic             valid_ff;
   qrm_pkg::rsp_type data_ff, data_in;

   logic [qrm_pkg::QW:0]            qinc [qrm_pkg::NLANE];
   logic [qrm_pkg::QW-1:0]          qr   [qrm_pkg::NLANE];
   logic signed [qrm_pkg::CW-1:0]   e    [qrm_pkg::NLANE];

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      for (int k = 0; k < qrm_pkg::NLANE; k++) begin
         qinc[k] = {1'b0, in_data.q[k]} + 1'b1;
         qr[k]   = qinc[k][qrm_pkg::QW:1];
         if (in_data.neg[k]) begin
            e[k] = (qr[k] > NEG_MAX) ? NEG_SAT : qrm_pkg::CW'(-qr[k]);
         end else begin
            e[k] = (qr[k] > POS_MAX) ? qrm_pkg::ONE_SAT : qr[k][qrm_pkg::CW-1:0];
         end
         if (in_data.zero) begin
            e[k] = (k % 4 == 0) ? qrm_pkg::ONE_SAT : '0;
         end
      end
      data_in.r00       = e[0];
      data_in.r01       = e[1];
      data_in.r02       = e[2];
      data_in.r10       = e[3];
      data_in.r11       = e[4];
      data_in.r12       = e[5];
      data_in.r20       = e[6];
      data_in.r21       = e[7];
      data_in.r22       = e[8];
      data_in.zero_quat = in_data.zero;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

/* rtl/core/quaternion_to_rotation_matrix.sv */
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix
// Q1.15 quaternion in, nine Q1.15 rotation matrix elements out, pipelined.
// ----------------------------------------------------------------------------
// One quaternion transfer per cycle goes in and one matrix transfer per cycle
// comes out while rsp_stall is low; at 16-bit components the stages are the
// product stage, numerator stage, 17 restoring division steps and the output
// stage. Each element is the exact ratio scaled by 2/N, N being the squared
// norm, rounded once to nearest with ties away from zero and saturated, so
// +1 reads as 32767. A zero quaternion gives the identity and sets zero_quat.
// The pipeline has no state between items; every stage holds its own valid
// bit and stalls independently, so bubbles close up and the next transfer is
// taken while a finished result still waits at the output register.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  qrm_pkg::req_type  req,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output qrm_pkg::rsp_type  rsp
);

   localparam int NS = qrm_pkg::NSTEP;

   // product stage
   logic              prod_valid, prod_ready, mult_in_ready;
   qrm_pkg::prod_type prod;

   // divider chain: slot i feeds step i, slot NS feeds the output stage
   logic             div_valid [NS+1];
   logic             div_ready [NS+1];
   qrm_pkg::div_type div_data  [NS+1];

   assign req_stall = !mult_in_ready;

   qrm_mult u_mult (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (mult_in_ready),
      .in_data   (req),
      .out_valid (prod_valid),
      .out_ready (prod_ready),
      .out_data  (prod)
   );

   qrm_numer u_numer (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prod_valid),
      .in_ready  (prod_ready),
      .in_data   (prod),
      .out_valid (div_valid[0]),
      .out_ready (div_ready[0]),
      .out_data  (div_data[0])
   );

   // first step resolves the integer quotient bit, the rest one fraction bit
   // each plus the rounding bit
   for (genvar i = 0; i < NS; i++) begin : g_step
      qrm_div_step #(
         .FIRST (i == 0)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (div_valid[i]),
         .in_ready  (div_ready[i]),
         .in_data   (div_data[i]),
         .out_valid (div_valid[i+1]),
         .out_ready (div_ready[i+1]),
         .out_data  (div_data[i+1])
      );
   end

   qrm_round u_round (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid[NS]),
      .in_ready  (div_ready[NS]),
      .in_data   (div_data[NS]),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .out_data  (rsp)
   );

   // identity on a zero quaternion
   a_zero_diag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.zero_quat |-> rsp.r00 == qrm_pkg::ONE_SAT &&
         rsp.r11 == qrm_pkg::ONE_SAT && rsp.r22 == qrm_pkg::ONE_SAT)
      else $error("zero quaternion without unit diagonal");

   a_zero_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.zero_quat |-> rsp.r01 == '0 && rsp.r02 == '0 &&
         rsp.r10 == '0 && rsp.r12 == '0 && rsp.r20 == '0 && rsp.r21 == '0)
      else $error("zero quaternion with non-zero off-diagonal");

   // input only held back when the product stage is full
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> prod_valid && !prod_ready)
      else $error("input stalled with room in product stage");

endmodule

/* verif/quaternion_to_rotation_matrix_tb.sv */
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix_tb
// Self-checking bench: random and corner quaternions against a bit-exact
// predictor of the 2/N-scaled rotation matrix, with random idling both sides.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix_tb;
   import qrm_pkg::*;

   localparam int LATENCY   = 20;
   localparam int CYC_LIMIT = 200000;
   localparam logic signed [CW-1:0] QMAX = CW'((1 << FW) - 1);
   localparam logic signed [CW-1:0] QMIN = CW'(1 << FW);

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp;

   req_type quat_queue[$];     // quaternions waiting to be driven
   rsp_type matrix_queue[$];   // predicted matrices, oldest first
   int      send_idle_pct = 37;
   int      recv_idle_pct = 47;
   bit      failed = 1'b0;
   int      cycles = 0;

   quaternion_to_rotation_matrix DUT (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   // round(num * 2^F / n), ties away from zero, then saturate; |num| <= 2n
   function automatic logic signed [CW-1:0] scale_element(longint num, longint n);
      longint mag, q;
      mag = (num < 0) ? -num : num;
      q = ((mag <<< (FW + 1)) / n + 1) >>> 1;
      if (num < 0) q = -q;
      if (q > longint'(QMAX)) q = longint'(QMAX);
      if (q < longint'(QMIN)) q = longint'(QMIN);
      return CW'(q);
   endfunction

   function automatic rsp_type rotation_of(req_type qin);
      rsp_type m;
      longint w, x, y, z, n;
      w = qin.qw; x = qin.qx; y = qin.qy; z = qin.qz;
      n = w*w + x*x + y*y + z*z;
      m = '0;
      if (n == 0) begin
         m.r00 = QMAX; m.r11 = QMAX; m.r22 = QMAX;
         m.zero_quat = 1'b1;
         return m;
      end
      m.r00 = scale_element(n - 2*(y*y + z*z), n);
      m.r01 = scale_element(2*(x*y + w*z), n);
      m.r02 = scale_element(2*(x*z - w*y), n);
      m.r10 = scale_element(2*(x*y - w*z), n);
      m.r11 = scale_element(n - 2*(x*x + z*z), n);
      m.r12 = scale_element(2*(y*z + w*x), n);
      m.r20 = scale_element(2*(x*z + w*y), n);
      m.r21 = scale_element(2*(y*z - w*x), n);
      m.r22 = scale_element(n - 2*(x*x + y*y), n);
      return m;
   endfunction

   function automatic req_type quat(int w, int x, int y, int z);
      req_type r;
      r.qw = CW'(w); r.qx = CW'(x); r.qy = CW'(y); r.qz = CW'(z);
      return r;
   endfunction

   // random quaternion: full range mostly, small or halved now and then
   function automatic req_type random_quat();
      req_type r;
      int pick;
      pick = $urandom_range(0, 9);
      r = req_type'({$urandom, $urandom});
      if (pick == 0) begin
         r.qw = CW'($urandom_range(0, 6) - 3); r.qx = CW'($urandom_range(0, 6) - 3);
         r.qy = CW'($urandom_range(0, 6) - 3); r.qz = CW'($urandom_range(0, 6) - 3);
      end else if (pick == 1) begin
         r.qw = r.qw >>> 1; r.qx = r.qx >>> 1; r.qy = r.qy >>> 1; r.qz = r.qz >>> 1;
      end
      return r;
   endfunction

   // driver: a transfer happens when valid is high and stall low at the edge
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (quat_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req       <= quat_queue[0];
            req_valid <= 1'b1;
            matrix_queue.push_back(rotation_of(quat_queue[0]));
            void'(quat_queue.pop_front());
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor and receiver stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         cycles <= cycles + 1;
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
         if (rsp_valid && !rsp_stall) begin
            if (matrix_queue.size() == 0) begin
               $display("%0t: unexpected transfer, actual %h", $time, rsp);
               failed <= 1'b1;
            end else begin
               if (rsp !== matrix_queue[0]) begin
                  $display("%0t: expected %h actual %h", $time, matrix_queue[0], rsp);
                  failed <= 1'b1;
               end
               void'(matrix_queue.pop_front());
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (cycles > CYC_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic run_phase(int send_pct, int recv_pct, int count);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int i = 0; i < count; i++) quat_queue.push_back(random_quat());
      while (quat_queue.size() > 0) @(posedge clock);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      // corner cases: zero, extremes, pure axes, ties and saturation
      quat_queue.push_back(quat(0, 0, 0, 0));
      quat_queue.push_back(quat(QMAX, 0, 0, 0));
      quat_queue.push_back(quat(-32768, 0, 0, 0));
      quat_queue.push_back(quat(0, -32768, 0, 0));
      quat_queue.push_back(quat(0, 0, -32768, 0));
      quat_queue.push_back(quat(0, 0, 0, -32768));
      quat_queue.push_back(quat(0, QMAX, 0, 0));
      quat_queue.push_back(quat(-32768, -32768, -32768, -32768));
      quat_queue.push_back(quat(QMAX, QMAX, QMAX, QMAX));
      quat_queue.push_back(quat(QMAX, -32768, QMAX, -32768));
      quat_queue.push_back(quat(1, 0, 0, 0));
      quat_queue.push_back(quat(0, 0, 0, 1));
      quat_queue.push_back(quat(1, 1, 1, 1));
      quat_queue.push_back(quat(-1, 1, -1, 1));
      quat_queue.push_back(quat(1, 1, 0, 0));
      quat_queue.push_back(quat(23170, 23170, 0, 0));
      quat_queue.push_back(quat(16384, 16384, 16384, 16384));
      quat_queue.push_back(quat(3, 1, 1, 0));
      quat_queue.push_back(quat(-1, -1, -1, -1));
      quat_queue.push_back(quat(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));
      run_phase(37, 47, 180);
      run_phase(47, 37, 180);
      run_phase(0, 0, 190);
      while (matrix_queue.size() > 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (!failed && matrix_queue.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

/* quaternion_to_rotation_matrix.f */
rtl/core/qrm_pkg.sv
rtl/core/qrm_mult.sv
rtl/core/qrm_numer.sv
rtl/core/qrm_div_step.sv
rtl/core/qrm_round.sv
rtl/core/quaternion_to_rotation_matrix.sv
verif/quaternion_to_rotation_matrix_tb.sv
